### rtl/core/homogeneous_point_transform_top_assert.svh
// assertion macros shared by the point transform rtl
// needs signals named clock and reset in the including module
`ifndef HOMOGENEOUS_POINT_TRANSFORM_TOP_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication
`define HPT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/hpt_pkg.sv
// constants and types for the homogeneous point transform
// no dependencies
`default_nettype none
package hpt_pkg;
   localparam int DW    = 32;          // data width
   localparam int FB    = 16;          // fraction bits
   localparam int PW    = 2 * DW;      // product width
   localparam int SW    = PW + 2;      // sum of three products
   localparam int VW    = SW - FB + 1; // row result with translation
   localparam int RW    = VW + 1;      // divider partial remainder
   localparam int NDIV  = DW;          // quotient bits, one per stage
   localparam int NREG  = 8;
   localparam int IW    = 8;           // csr index width
   localparam int CW    = 64;          // csr data width

   localparam logic [IW-1:0] REG_LAST = IW'(NREG - 1);
   localparam logic signed [VW-1:0] V_ONE = VW'(1) <<< FB;
   localparam logic [DW-1:0] POS_LIM = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] NEG_LIM = {1'b1, {(DW-1){1'b0}}};

   typedef struct packed {
      logic             valid;
      logic             wz;
      logic             wone;
      logic             dov;
      logic [VW-1:0]    ud;
      logic [2:0][DW-1:0] dq;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [DW-1:0] num;
      logic [DW-1:0] quo;
      logic          neg;
      logic          pre_ov;
   } lane_type;
endpackage
`default_nettype wire

### rtl/core/homogeneous_point_transform_top.sv
// point transform by a 4x4 matrix with perspective divide, Q16.16
// depends on hpt_pkg and homogeneous_point_transform_top_assert.svh
//
// channel  dir  handshake           beat
// req      in   req_valid/req_stall px, py, pz
// rsp      out  rsp_valid/rsp_stall qx, qy, qz, w_zero, overflow
// csr      in   csr_valid/csr_ready index, 64-bit coefficient pair
//
// one point per cycle while the pipe is not held; registers in order: input, products, row sums,
// translation, magnitudes, divider setup, 32 restoring divider stages, output
// the whole pipe advances together; it holds while a result beat waits under
// rsp_stall, and req sees stall for exactly those cycles
// reset clears all valid bits and loads the identity matrix
`default_nettype none
`include "homogeneous_point_transform_top_assert.svh"
module homogeneous_point_transform_top
   import hpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [DW-1:0] req_px,
   input  wire logic signed [DW-1:0] req_py,
   input  wire logic signed [DW-1:0] req_pz,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [DW-1:0]      rsp_qx,
   output logic signed [DW-1:0]      rsp_qy,
   output logic signed [DW-1:0]      rsp_qz,
   output logic                      rsp_w_zero,
   output logic                      rsp_overflow,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [IW-1:0]        csr_index,
   input  wire logic [CW-1:0]        csr_wdata
);
   logic [CW-1:0] coef_ff [NREG];
   logic signed [DW-1:0] mat [16];
   logic adv;

   // stage registers
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [DW-1:0]  pt_ff [3];
   logic signed [PW-1:0]  prod_ff [12], prod_in [12];
   logic signed [SW-1:0]  sum_ff [4], sum_in [4];
   logic signed [VW-1:0]  row_ff [4], row_in [4];
   side_type              sd5_ff, sd5_in;
   logic [VW-1:0]         un5_ff [3], un5_in [3];
   logic [2:0]            neg5_ff, neg5_in;
   side_type              side_ff [NDIV+1];
   lane_type              lane_ff [NDIV+1][3];
   side_type              side_in [NDIV+1];
   lane_type              lane_in [NDIV+1][3];
   logic                  out_valid_ff;
   logic [2:0][DW-1:0]    oq_ff, oq_in;
   logic                  owz_ff, oov_ff, oov_in;

   assign adv       = !(out_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= CW'(64'd65536);
         coef_ff[1] <= '0;
         coef_ff[2] <= CW'(64'd281474976710656);
         coef_ff[3] <= '0;
         coef_ff[4] <= '0;
         coef_ff[5] <= CW'(64'd65536);
         coef_ff[6] <= '0;
         coef_ff[7] <= CW'(64'd281474976710656);
      end else if (csr_valid && csr_index <= REG_LAST) begin
         coef_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   always_comb begin
      for (int k = 0; k < 16; k++) begin
         mat[k] = (k % 2 == 1) ? coef_ff[k / 2][2*DW-1:DW] : coef_ff[k / 2][DW-1:0];
      end
      for (int r = 0; r < 4; r++) begin
         prod_in[r]     = PW'(mat[r])     * PW'(pt_ff[0]);
         prod_in[r + 4] = PW'(mat[r + 4]) * PW'(pt_ff[1]);
         prod_in[r + 8] = PW'(mat[r + 8]) * PW'(pt_ff[2]);
         sum_in[r] = SW'(prod_ff[r]) + SW'(prod_ff[r + 4]) + SW'(prod_ff[r + 8]);
         // floor shift of the exact sum then add translation
         row_in[r] = VW'(sum_ff[r] >>> FB) + VW'(mat[r + 12]);
      end
   end

   // magnitudes and the results that need no divide
   always_comb begin
      sd5_in.valid = v4_ff;
      sd5_in.wz    = (row_ff[3] == '0);
      sd5_in.wone  = (row_ff[3] == V_ONE);
      sd5_in.ud    = row_ff[3][VW-1] ? VW'(-row_ff[3]) : VW'(row_ff[3]);
      sd5_in.dov   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         neg5_in[i] = row_ff[i][VW-1] ^ row_ff[3][VW-1];
         un5_in[i]  = row_ff[i][VW-1] ? VW'(-row_ff[i]) : VW'(row_ff[i]);
         if (sd5_in.wz) begin
            if (row_ff[i] == '0) sd5_in.dq[i] = '0;
            else if (row_ff[i][VW-1]) sd5_in.dq[i] = NEG_LIM;
            else sd5_in.dq[i] = POS_LIM;
         end else if (row_ff[i][VW-1:DW-1] == '0 || row_ff[i][VW-1:DW-1] == '1) begin
            sd5_in.dq[i] = row_ff[i][DW-1:0];
         end else begin
            sd5_in.dov   = 1'b1;
            sd5_in.dq[i] = row_ff[i][VW-1] ? NEG_LIM : POS_LIM;
         end
      end
   end

   // divider setup and restoring stages, one quotient bit each
   always_comb begin
      logic [RW-1:0] r2;
      side_in[0] = sd5_ff;
      for (int i = 0; i < 3; i++) begin
         lane_in[0][i].neg    = neg5_ff[i];
         lane_in[0][i].pre_ov = RW'(un5_ff[i][VW-1:FB]) >= RW'(sd5_ff.ud);
         lane_in[0][i].rem    = RW'(un5_ff[i][VW-1:FB]);
         lane_in[0][i].num    = {un5_ff[i][FB-1:0], {(DW-FB){1'b0}}};
         lane_in[0][i].quo    = '0;
      end
      for (int k = 1; k <= NDIV; k++) begin
         side_in[k] = side_ff[k-1];
         for (int i = 0; i < 3; i++) begin
            lane_in[k][i] = lane_ff[k-1][i];
            r2 = {lane_ff[k-1][i].rem[RW-2:0], lane_ff[k-1][i].num[DW-1]};
            lane_in[k][i].num = {lane_ff[k-1][i].num[DW-2:0], 1'b0};
            if (r2 >= RW'(side_ff[k-1].ud)) begin
               lane_in[k][i].rem = r2 - RW'(side_ff[k-1].ud);
               lane_in[k][i].quo = {lane_ff[k-1][i].quo[DW-2:0], 1'b1};
            end else begin
               lane_in[k][i].rem = r2;
               lane_in[k][i].quo = {lane_ff[k-1][i].quo[DW-2:0], 1'b0};
            end
         end
      end
   end

   // saturate, apply sign and pick the path
   always_comb begin
      logic [DW-1:0] lim, qm;
      logic          lov, dov_any;
      dov_any = 1'b0;
      oq_in   = '0;
      for (int i = 0; i < 3; i++) begin
         lim = lane_ff[NDIV][i].neg ? NEG_LIM : POS_LIM;
         lov = lane_ff[NDIV][i].pre_ov || (lane_ff[NDIV][i].quo > lim);
         qm  = lov ? lim : lane_ff[NDIV][i].quo;
         dov_any = dov_any | lov;
         if (side_ff[NDIV].wz || side_ff[NDIV].wone) oq_in[i] = side_ff[NDIV].dq[i];
         else if (lane_ff[NDIV][i].neg) oq_in[i] = ~qm + 1'b1;
         else oq_in[i] = qm;
      end
      if (side_ff[NDIV].wz) oov_in = 1'b0;
      else if (side_ff[NDIV].wone) oov_in = side_ff[NDIV].dov;
      else oov_in = dov_any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         sd5_ff.valid <= 1'b0;
         for (int k = 0; k <= NDIV; k++) side_ff[k].valid <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff    <= req_valid;
         pt_ff[0] <= req_px;
         pt_ff[1] <= req_py;
         pt_ff[2] <= req_pz;
         v2_ff    <= v1_ff;
         prod_ff  <= prod_in;
         v3_ff    <= v2_ff;
         sum_ff   <= sum_in;
         v4_ff    <= v3_ff;
         row_ff   <= row_in;
         sd5_ff   <= sd5_in;
         un5_ff   <= un5_in;
         neg5_ff  <= neg5_in;
         side_ff  <= side_in;
         lane_ff  <= lane_in;
         out_valid_ff <= side_ff[NDIV].valid;
         oq_ff    <= oq_in;
         owz_ff   <= side_ff[NDIV].wz;
         oov_ff   <= oov_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_qx       = oq_ff[0];
   assign rsp_qy       = oq_ff[1];
   assign rsp_qz       = oq_ff[2];
   assign rsp_w_zero   = owz_ff;
   assign rsp_overflow = oov_ff;

   `HPT_ASSERT_NOW(a_wz_no_ovf, rsp_valid && rsp_w_zero, !rsp_overflow, "w zero with overflow")
   `HPT_ASSERT_NOW(a_wz_limits, rsp_valid && rsp_w_zero,
      rsp_qx == POS_LIM || rsp_qx == NEG_LIM || rsp_qx == '0, "w zero x not a limit")
   `HPT_ASSERT_NEXT(a_hold_pipe, rsp_valid && rsp_stall,
      $stable(side_ff[NDIV].valid) && $stable(v1_ff), "pipe moved under stall")
   `HPT_ASSERT_NOW(a_ovf_limit, rsp_valid && rsp_overflow,
      rsp_qx == POS_LIM || rsp_qx == NEG_LIM || rsp_qy == POS_LIM || rsp_qy == NEG_LIM ||
      rsp_qz == POS_LIM || rsp_qz == NEG_LIM, "overflow without a clamped output")
endmodule
`default_nettype wire

### test/point_transform_checker.sv
// watches the point transform channels, predicts each result beat and compares
// depends on hpt_pkg
`default_nettype none
module point_transform_checker
   import hpt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic signed [DW-1:0] req_px,
   input  wire logic signed [DW-1:0] req_py,
   input  wire logic signed [DW-1:0] req_pz,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic signed [DW-1:0] rsp_qx,
   input  wire logic signed [DW-1:0] rsp_qy,
   input  wire logic signed [DW-1:0] rsp_qz,
   input  wire logic                 rsp_w_zero,
   input  wire logic                 rsp_overflow,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [IW-1:0]        csr_index,
   input  wire logic [CW-1:0]        csr_wdata,
   output int                        fail_count,
   output int                        pending
);
   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic signed [DW-1:0] qx;
      logic signed [DW-1:0] qy;
      logic signed [DW-1:0] qz;
      logic                 w_zero;
      logic                 overflow;
   } point_beat_type;

   logic [CW-1:0] matrix_pairs [NREG];
   point_beat_type expected_points [$];

   function automatic wide_type entry(input int k);
      logic [CW-1:0] pair;
      logic signed [DW-1:0] half;
      pair = matrix_pairs[k / 2];
      half = (k % 2) ? pair[63:32] : pair[31:0];
      return wide_type'(half);
   endfunction

   // exact row sum, floored to the fraction point, then the translation entry
   function automatic wide_type row_sum(input int r, input wide_type x, input wide_type y,
                                        input wide_type z);
      wide_type acc;
      acc = entry(r) * x + entry(r + 4) * y + entry(r + 8) * z;
      return (acc >>> FB) + entry(r + 12);
   endfunction

   function automatic point_beat_type transform_point(input logic signed [DW-1:0] px,
                                                      input logic signed [DW-1:0] py,
                                                      input logic signed [DW-1:0] pz);
      wide_type x, y, z, w, v, q;
      wide_type hi_lim, lo_lim;
      logic signed [DW-1:0] res [3];
      logic ov;
      point_beat_type beat;
      x = px;
      y = py;
      z = pz;
      hi_lim = (wide_type'(1) <<< (DW - 1)) - 1;
      lo_lim = -hi_lim - 1;
      w = row_sum(3, x, y, z);
      ov = 1'b0;
      for (int i = 0; i < 3; i++) begin
         v = row_sum(i, x, y, z);
         if (w == 0) begin
            q = (v > 0) ? hi_lim : (v < 0) ? lo_lim : 0;
         end else if (w == (wide_type'(1) <<< FB)) begin
            q = v;
         end else begin
            q = (v <<< FB) / w;
         end
         if (q > hi_lim) begin
            q = hi_lim;
            ov = 1'b1;
         end else if (q < lo_lim) begin
            q = lo_lim;
            ov = 1'b1;
         end
         res[i] = q[DW-1:0];
      end
      beat.qx = res[0];
      beat.qy = res[1];
      beat.qz = res[2];
      beat.w_zero = (w == 0);
      beat.overflow = (w == 0) ? 1'b0 : ov;
      return beat;
   endfunction

   always @(posedge clock) begin
      point_beat_type want;
      if (reset) begin
         matrix_pairs[0] = 64'd65536;
         matrix_pairs[1] = 64'd0;
         matrix_pairs[2] = 64'd281474976710656;
         matrix_pairs[3] = 64'd0;
         matrix_pairs[4] = 64'd0;
         matrix_pairs[5] = 64'd65536;
         matrix_pairs[6] = 64'd0;
         matrix_pairs[7] = 64'd281474976710656;
      end else begin
         if (csr_valid && csr_ready && csr_index <= REG_LAST)
            matrix_pairs[csr_index[2:0]] = csr_wdata;
         if (req_valid && !req_stall)
            expected_points.push_back(transform_point(req_px, req_py, req_pz));
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $error("result beat with no point outstanding");
               fail_count++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_qx !== want.qx) begin
                  $error("qx expected %h actual %h", want.qx, rsp_qx);
                  fail_count++;
               end
               if (rsp_qy !== want.qy) begin
                  $error("qy expected %h actual %h", want.qy, rsp_qy);
                  fail_count++;
               end
               if (rsp_qz !== want.qz) begin
                  $error("qz expected %h actual %h", want.qz, rsp_qz);
                  fail_count++;
               end
               if (rsp_w_zero !== want.w_zero) begin
                  $error("w_zero expected %b actual %b", want.w_zero, rsp_w_zero);
                  fail_count++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow expected %b actual %b", want.overflow, rsp_overflow);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_points.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule
`default_nettype wire

### test/testbench.sv
// stimulus and verdict for the homogeneous point transform
// depends on hpt_pkg, homogeneous_point_transform_top and point_transform_checker
`default_nettype none
module testbench;
   import hpt_pkg::*;

   localparam int   LIMIT_CYCLES = 400000;
   localparam int   DRAIN_CYCLES = 60;
   localparam logic [IW-1:0] REG_UNUSED_LOW  = IW'(REG_LAST + 1);
   localparam logic [IW-1:0] REG_UNUSED_HIGH = {IW{1'b1}};
   localparam logic [31:0] ONE_Q = 32'h0001_0000;
   localparam logic [31:0] MAX_Q = 32'h7fff_ffff;
   localparam logic [31:0] MIN_Q = 32'h8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [DW-1:0] req_px = '0, req_py = '0, req_pz = '0;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [IW-1:0] csr_index = '0;
   logic [CW-1:0] csr_wdata = '0;
   wire logic req_stall, rsp_valid, rsp_w_zero, rsp_overflow, csr_ready;
   wire logic signed [DW-1:0] rsp_qx, rsp_qy, rsp_qz;
   int fail_count, pending;
   int cycle_count = 0;
   bit sender_quiet = 1'b0;

   always #5 clock = ~clock;

   homogeneous_point_transform_top dut (.*);

   point_transform_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off, a stretch with no stall, then random stalls again
   initial begin
      int hold;
      repeat (400) begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < 24);
      end
      @(negedge clock);
      rsp_stall <= 1'b1;
      for (hold = 0; hold < 200; hold++) @(negedge clock);
      rsp_stall <= 1'b0;
      repeat (600) @(negedge clock);
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(0, 99) < 24);
      end
   end

   task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
      @(negedge clock);
      if (!sender_quiet) begin
         while ($urandom_range(0, 99) < 24) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_px <= x;
      req_py <= y;
      req_pz <= z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_pair(input logic [IW-1:0] idx, input logic [CW-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] random_value(input bit coef);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 4))
               0: return MAX_Q;
               1: return MIN_Q;
               2: return ONE_Q;
               3: return -ONE_Q;
               default: return 32'd0;
            endcase
         end
         2: return coef ? 32'd0 : $urandom();
         default: return $signed($urandom_range(0, 1 << 19)) - (1 << 18)
                          + (coef ? 0 : $signed($urandom_range(0, 1 << 23)) - (1 << 22));
      endcase
   endfunction

   task automatic write_matrix(input int style);
      logic [31:0] lo, hi;
      for (int i = 0; i < NREG; i++) begin
         case (style)
            0: begin
               lo = random_value(1'b1);
               hi = random_value(1'b1);
            end
            1: begin
               lo = MAX_Q;
               hi = MAX_Q;
            end
            2: begin
               lo = MIN_Q;
               hi = MIN_Q;
            end
            default: begin
               lo = $urandom();
               hi = $urandom();
            end
         endcase
         // at random set the w translation to one so the divide path sees sensible quotients
         if (style == 0 && i == 7 && $urandom_range(0, 1)) hi = ONE_Q;
         write_pair(IW'(i), {hi, lo});
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity: pass-through with extremes
      send_point(MAX_Q, MIN_Q, 32'd0);
      send_point(MIN_Q, MAX_Q, 32'hffff_ffff);
      send_point(ONE_Q, -ONE_Q, 32'h0000_8000);
      send_point(32'h1234_5678, 32'hedcb_a987, 32'h0000_0001);
      drain();

      // w row all zero: zero divide, signs of numerators
      write_pair(IW'(1), 64'd0);
      write_pair(IW'(3), 64'd0);
      write_pair(IW'(5), {32'd0, ONE_Q});
      write_pair(IW'(7), {32'd0, 32'd0});
      write_pair(REG_UNUSED_LOW, '1);
      write_pair(REG_UNUSED_HIGH, '1);
      send_point(ONE_Q, -ONE_Q, 32'd0);
      send_point(32'd0, 32'd0, 32'd0);
      send_point(MIN_Q, MAX_Q, 32'd5);
      drain();

      // perspective: w = z, translation pushes x past the range
      write_pair(IW'(5), {ONE_Q, ONE_Q});
      write_pair(IW'(6), {32'd0, MAX_Q});
      send_point(ONE_Q, ONE_Q, 32'h0000_0002);
      send_point(MAX_Q, MIN_Q, 32'hffff_ffff);
      send_point(32'h0003_0000, 32'h0002_0000, 32'h0000_8000);
      send_point(MAX_Q, MAX_Q, MIN_Q);
      send_point(32'h0001_0000, 32'hffff_0000, 32'hfffe_0000);
      send_point(32'd0, 32'd0, 32'd0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         write_matrix(phase < 3 ? 0 : phase - 2);
         sender_quiet = (phase == 1);
         for (int n = 0; n < 170; n++)
            send_point(random_value(1'b0), random_value(1'b0), random_value(1'b0));
         drain();
      end
      sender_quiet = 1'b0;

      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire
